// ===== src/adsr_pkg.sv =====
// Shared widths, constants and codes of the ADSR envelope gain block.
`default_nettype none

package adsr_pkg;

    localparam int LEVEL_W   = 17;                 // Q1.16 level, 0 to 1.0 inclusive
    localparam int FRAC_W    = 16;                 // fraction bits of the level
    localparam int DUR_W     = 24;                 // duration register width
    localparam int NUM_W     = DUR_W + LEVEL_W;    // ramp numerator width
    localparam int CFG_IDX_W = 2;

    localparam logic [LEVEL_W-1:0] ONE_Q16 = LEVEL_W'(1) << FRAC_W;

    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_ATTACK  = 3'd1,
        ST_DECAY   = 3'd2,
        ST_SUSTAIN = 3'd3,
        ST_RELEASE = 3'd4
    } t_stage;

endpackage

`default_nettype wire

// ===== src/adsr_in_if.sv =====
// Input frame channel: stereo samples with trigger and release events.
`default_nettype none

interface adsr_in_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;
    logic                          trigger_event;
    logic                          release_event;

    modport source (output valid, output left_in, output right_in,
                    output trigger_event, output release_event, input ready);
    modport sink   (input valid, input left_in, input right_in,
                    input trigger_event, input release_event, output ready);
endinterface

`default_nettype wire

// ===== src/adsr_out_if.sv =====
// Output frame channel: scaled stereo samples with envelope level and stage.
`default_nettype none

interface adsr_out_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
    logic [16:0]                   env_level;
    logic [2:0]                    env_stage;

    modport source (output valid, output left_out, output right_out,
                    output env_level, output env_stage, input ready);
    modport sink   (input valid, input left_out, input right_out,
                    input env_level, input env_stage, output ready);
endinterface

`default_nettype wire

// ===== src/adsr_mul.sv =====
// Shared signed multiplier with registered product.
`default_nettype none

module adsr_mul import adsr_pkg::*; #(
    parameter int A_W = 25
) (
    input  logic                       i_clk,
    input  logic signed [A_W-1:0]      i_a,
    input  logic signed [LEVEL_W:0]    i_b,
    output logic signed [A_W+LEVEL_W:0] o_p
);

    logic signed [A_W+LEVEL_W:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= (A_W+LEVEL_W+1)'(i_a) * (A_W+LEVEL_W+1)'(i_b);
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

// ===== src/adsr_div.sv =====
// Restoring divider, one quotient bit per cycle, for the ramp levels.
`default_nettype none

module adsr_div import adsr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [NUM_W-1:0]   i_num,
    input  logic [DUR_W-1:0]   i_den,
    output logic               o_done,
    output logic [LEVEL_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(LEVEL_W);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [DUR_W-1:0]   r_rem;
    logic [LEVEL_W-1:0] r_low;
    logic [LEVEL_W-1:0] r_quot;
    logic [DUR_W-1:0]   r_den;

    logic [DUR_W:0] trial;
    logic [DUR_W:0] diff;
    logic           ge;

    always_comb begin
        trial = {r_rem, r_low[LEVEL_W-1]};
        diff  = trial - {1'b0, r_den};
        ge    = trial >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(LEVEL_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // The numerator is below den * 2^17, so the upper part starts below den.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num[NUM_W-1:LEVEL_W];
            r_low <= i_num[LEVEL_W-1:0];
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem  <= ge ? diff[DUR_W-1:0] : trial[DUR_W-1:0];
            r_low  <= {r_low[LEVEL_W-2:0], 1'b0};
            r_quot <= {r_quot[LEVEL_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

// ===== src/adsr_envelope_gain.sv =====
// Top level: linear ADSR envelope applied to a stereo stream.
//
//   channel   dir  handshake        payload
//   i_in      in   valid/ready      left_in, right_in, trigger_event, release_event
//   o_out     out  valid/ready      left_out, right_out, env_level, env_stage
//   cfg       in   i_cfg_we         i_cfg_idx, i_cfg_data
//
// A ramp frame passes from accept to result through the numerator product,
// the divider start, the divider steps, the step that takes the quotient, two
// channel products and the steps that land the result; other frames go straight
// to the channel products. Input ready is high only in the idle step, from the
// cycle after the push, so a frame is taken only once the last is pushed; a
// full output register holds the push. Reset is synchronous and clears state and config.
`default_nettype none

module adsr_envelope_gain import adsr_pkg::*; #(
    parameter int SAMPLE_BITS = 24,
    parameter int COUNT_BITS  = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    adsr_in_if.sink              i_in,
    adsr_out_if.source           o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DUR_W-1:0]     i_cfg_data
);

    localparam int WW = (COUNT_BITS > DUR_W) ? COUNT_BITS : DUR_W;
    localparam int MW = (SAMPLE_BITS > DUR_W + 1) ? SAMPLE_BITS : DUR_W + 1;
    localparam int PW = MW + LEVEL_W + 1;
    localparam logic [COUNT_BITS-1:0] CMAX = '1;

    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_NUM,
        SQ_DIVS,
        SQ_DIVW,
        SQ_LEFT,
        SQ_RIGHT,
        SQ_FIN,
        SQ_PUSH
    } t_seq;

    // configuration
    logic [DUR_W-1:0]   r_attack;
    logic [DUR_W-1:0]   r_decay;
    logic [LEVEL_W-1:0] r_sustain;
    logic [DUR_W-1:0]   r_release;

    // envelope state and sequencer
    t_seq                   r_seq;
    t_stage                 r_stage;
    logic [COUNT_BITS-1:0]  r_count;
    logic [LEVEL_W-1:0]     r_level;
    logic                   r_sub;
    logic [DUR_W-1:0]       r_num_a;
    logic [LEVEL_W-1:0]     r_num_b;
    logic [DUR_W-1:0]       r_den;
    logic signed [SAMPLE_BITS-1:0] r_left_in;
    logic signed [SAMPLE_BITS-1:0] r_right_in;
    logic signed [SAMPLE_BITS-1:0] r_left_res;
    logic signed [SAMPLE_BITS-1:0] r_right_res;

    // output register
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_left;
    logic signed [SAMPLE_BITS-1:0] r_out_right;
    logic [LEVEL_W-1:0]            r_out_level;
    t_stage                        r_out_stage;

    // step decode
    logic [LEVEL_W-1:0]    sus;
    t_stage                s1;
    logic [COUNT_BITS-1:0] c1;
    logic [COUNT_BITS-1:0] c2;
    logic [DUR_W-1:0]      dur;
    logic                  fin;
    t_stage                n_stage;
    logic [COUNT_BITS-1:0] n_count;
    logic [LEVEL_W-1:0]    n_level;
    logic                  n_ramp;
    logic                  n_sub;
    logic [DUR_W-1:0]      n_num_a;
    logic [LEVEL_W-1:0]    n_num_b;

    logic signed [MW-1:0]      mul_a;
    logic signed [LEVEL_W:0]   mul_b;
    logic signed [PW-1:0]      prod;
    logic                      div_start;
    logic                      div_done;
    logic [LEVEL_W-1:0]        div_quot;
    logic                      accept;

    assign accept = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack  <= '0;
            r_decay   <= '0;
            r_sustain <= '0;
            r_release <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ATTACK:  r_attack  <= i_cfg_data;
                CFG_DECAY:   r_decay   <= i_cfg_data;
                CFG_SUSTAIN: r_sustain <= i_cfg_data[LEVEL_W-1:0];
                CFG_RELEASE: r_release <= i_cfg_data;
                default:     ;
            endcase
        end
    end

    always_comb begin
        sus = (r_sustain > ONE_Q16) ? ONE_Q16 : r_sustain;

        s1 = i_in.trigger_event ? ST_ATTACK : r_stage;
        c1 = i_in.trigger_event ? '0 : r_count;
        if (i_in.release_event && s1 != ST_IDLE) begin
            s1 = ST_RELEASE;
            c1 = '0;
        end
        c2 = (c1 == CMAX) ? c1 : c1 + COUNT_BITS'(1);

        unique case (s1)
            ST_ATTACK:  dur = r_attack;
            ST_DECAY:   dur = r_decay;
            ST_RELEASE: dur = r_release;
            default:    dur = r_attack;
        endcase
        fin = (dur == '0) || (WW'(c2) >= WW'(dur));

        n_stage = s1;
        n_count = c2;
        n_level = '0;
        n_ramp  = 1'b0;
        n_sub   = 1'b0;
        // on a ramp the count is below the duration, so it fits the divider
        n_num_a = DUR_W'(c2);
        n_num_b = ONE_Q16;
        unique case (s1)
            ST_ATTACK: begin
                if (fin) begin
                    n_level = ONE_Q16;
                    n_stage = ST_DECAY;
                    n_count = '0;
                end else begin
                    n_ramp = 1'b1;
                end
            end
            ST_DECAY: begin
                n_num_b = ONE_Q16 - sus;
                n_sub   = 1'b1;
                if (fin) begin
                    n_level = sus;
                    n_stage = ST_SUSTAIN;
                    n_count = '0;
                end else begin
                    n_ramp = 1'b1;
                end
            end
            ST_SUSTAIN: begin
                n_level = sus;
            end
            ST_RELEASE: begin
                n_num_a = DUR_W'(WW'(dur) - WW'(c2));
                n_num_b = sus;
                if (fin) begin
                    n_stage = ST_IDLE;
                end else begin
                    n_ramp = 1'b1;
                end
            end
            default: begin
                n_stage = ST_IDLE;
            end
        endcase
    end

    // shared multiplier operands follow the sequencer step
    always_comb begin
        case (r_seq)
            SQ_LEFT: begin
                mul_a = MW'(r_left_in);
                mul_b = $signed({1'b0, r_level});
            end
            SQ_RIGHT: begin
                mul_a = MW'(r_right_in);
                mul_b = $signed({1'b0, r_level});
            end
            default: begin
                mul_a = $signed(MW'(r_num_a));
                mul_b = $signed({1'b0, r_num_b});
            end
        endcase
    end

    assign div_start = (r_seq == SQ_DIVS);

    adsr_mul #(
        .A_W (MW)
    ) u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    adsr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (prod[NUM_W-1:0]),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq       <= SQ_IDLE;
            r_stage     <= ST_IDLE;
            r_count     <= '0;
            r_level     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_out.ready && r_seq != SQ_PUSH) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_seq)
                SQ_IDLE: begin
                    if (accept) begin
                        r_stage    <= n_stage;
                        r_count    <= n_count;
                        r_level    <= n_level;
                        r_sub      <= n_sub;
                        r_num_a    <= n_num_a;
                        r_num_b    <= n_num_b;
                        r_den      <= dur;
                        r_left_in  <= i_in.left_in;
                        r_right_in <= i_in.right_in;
                        r_seq      <= n_ramp ? SQ_NUM : SQ_LEFT;
                    end
                end
                SQ_NUM: begin
                    r_seq <= SQ_DIVS;
                end
                SQ_DIVS: begin
                    r_seq <= SQ_DIVW;
                end
                SQ_DIVW: begin
                    if (div_done) begin
                        r_level <= r_sub ? ONE_Q16 - div_quot : div_quot;
                        r_seq   <= SQ_LEFT;
                    end
                end
                SQ_LEFT: begin
                    r_seq <= SQ_RIGHT;
                end
                SQ_RIGHT: begin
                    // the product shifted by 16 is the floor of sample * level / 2^16
                    r_left_res <= prod[SAMPLE_BITS+FRAC_W-1:FRAC_W];
                    r_seq      <= SQ_FIN;
                end
                SQ_FIN: begin
                    r_right_res <= prod[SAMPLE_BITS+FRAC_W-1:FRAC_W];
                    r_seq       <= SQ_PUSH;
                end
                SQ_PUSH: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_left  <= r_left_res;
                        r_out_right <= r_right_res;
                        r_out_level <= r_level;
                        r_out_stage <= r_stage;
                        r_seq       <= SQ_IDLE;
                    end
                end
                default: begin
                    r_seq <= SQ_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready      = (r_seq == SQ_IDLE);
    assign o_out.valid     = r_out_valid;
    assign o_out.left_out  = r_out_left;
    assign o_out.right_out = r_out_right;
    assign o_out.env_level = r_out_level;
    assign o_out.env_stage = r_out_stage;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench of adsr_envelope_gain: directed and random envelopes, scored in order.
`timescale 1ns / 1ps

module testbench import adsr_pkg::*;;

    localparam int SAMPLE_BITS   = 24;
    localparam int COUNT_BITS    = 24;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int NUM_PHASES    = 13;
    localparam int PHASE_FRAMES  = 98;
    localparam int LONG_HOLD     = 400;
    localparam int DRAIN_CYCLES  = 40;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    typedef struct {
        t_sample left_s;
        t_sample right_s;
        logic    trig;
        logic    rel;
    } t_frame;

    typedef struct {
        logic [SAMPLE_BITS-1:0] left_s;
        logic [SAMPLE_BITS-1:0] right_s;
        logic [LEVEL_W-1:0]     level;
        logic [2:0]             stage;
    } t_gain_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [DUR_W-1:0]     i_cfg_data;

    adsr_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) in_ch ();
    adsr_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) out_ch ();

    adsr_envelope_gain #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_ch),
        .o_out     (out_ch),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // envelope mirror: configuration and state
    logic [DUR_W-1:0]      attack_len;
    logic [DUR_W-1:0]      decay_len;
    logic [LEVEL_W-1:0]    sustain_cfg;
    logic [DUR_W-1:0]      release_len;
    t_stage                env_stage_q;
    logic [COUNT_BITS-1:0] env_count_q;
    logic [LEVEL_W-1:0]    env_level_q;

    t_frame       pending_q[$];
    t_gain_result scaled_frames_q[$];
    t_frame       offered;

    int  send_idle_pct;
    int  recv_idle_pct;
    int  hold_left;
    logic long_hold_arm;
    logic long_hold_done;
    int  error_count;
    int  cycle_count;

    function automatic logic [SAMPLE_BITS-1:0] apply_gain(input t_sample s,
                                                          input logic [LEVEL_W-1:0] lvl);
        longint p;
        p = longint'(s) * longint'(lvl);
        return SAMPLE_BITS'(p >>> FRAC_W);
    endfunction

    function automatic t_gain_result envelope_step(input t_frame f);
        longint unsigned sus;
        longint unsigned dur;
        longint unsigned cnt;
        t_gain_result    r;
        sus = (sustain_cfg > ONE_Q16) ? longint'(ONE_Q16) : longint'(sustain_cfg);
        if (f.trig) begin
            env_stage_q = ST_ATTACK;
            env_count_q = '0;
        end
        if (f.rel && env_stage_q != ST_IDLE) begin
            env_stage_q = ST_RELEASE;
            env_count_q = '0;
        end
        if (env_count_q != '1)
            env_count_q = env_count_q + 1'b1;
        cnt = env_count_q;
        case (env_stage_q)
            ST_ATTACK: begin
                dur = attack_len;
                if (dur == 0 || cnt >= dur) begin
                    env_level_q = ONE_Q16;
                    env_stage_q = ST_DECAY;
                    env_count_q = '0;
                end else begin
                    env_level_q = LEVEL_W'((cnt << FRAC_W) / dur);
                end
            end
            ST_DECAY: begin
                dur = decay_len;
                if (dur == 0 || cnt >= dur) begin
                    env_level_q = LEVEL_W'(sus);
                    env_stage_q = ST_SUSTAIN;
                    env_count_q = '0;
                end else begin
                    env_level_q = LEVEL_W'(longint'(ONE_Q16)
                                           - (cnt * (longint'(ONE_Q16) - sus)) / dur);
                end
            end
            ST_SUSTAIN: begin
                env_level_q = LEVEL_W'(sus);
            end
            ST_RELEASE: begin
                dur = release_len;
                // count is left as is when release runs out
                if (dur == 0 || cnt >= dur) begin
                    env_level_q = '0;
                    env_stage_q = ST_IDLE;
                end else begin
                    env_level_q = LEVEL_W'((sus * (dur - cnt)) / dur);
                end
            end
            default: begin
                env_stage_q = ST_IDLE;
                env_level_q = '0;
            end
        endcase
        r.left_s  = apply_gain(f.left_s, env_level_q);
        r.right_s = apply_gain(f.right_s, env_level_q);
        r.level   = env_level_q;
        r.stage   = env_stage_q;
        return r;
    endfunction

    function automatic t_sample random_sample();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 3)
            return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        else if (pick < 6)
            return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        else if (pick < 8)
            return '0;
        else if (pick < 10)
            return '1;
        return SAMPLE_BITS'($urandom());
    endfunction

    task automatic push_frame(input t_sample l, input t_sample r, input logic trig,
                              input logic rel);
        t_frame f;
        f.left_s  = l;
        f.right_s = r;
        f.trig    = trig;
        f.rel     = rel;
        pending_q.push_back(f);
    endtask

    // mostly whole notes (trigger, hold, release, tail), some stray events
    task automatic add_random_frames(input int n);
        int added;
        int hold_len;
        int tail_len;
        logic stray;
        added = 0;
        while (added < n) begin
            if ($urandom_range(0, 99) < 75) begin
                hold_len = $urandom_range(0, 40);
                tail_len = $urandom_range(0, 30);
                push_frame(random_sample(), random_sample(), 1'b1, 1'b0);
                for (int k = 0; k < hold_len; k++) begin
                    stray = ($urandom_range(0, 99) < 5);
                    push_frame(random_sample(), random_sample(), stray, 1'b0);
                end
                push_frame(random_sample(), random_sample(), 1'b0, 1'b1);
                for (int k = 0; k < tail_len; k++) begin
                    stray = ($urandom_range(0, 99) < 5);
                    push_frame(random_sample(), random_sample(), 1'b0, stray);
                end
                added += hold_len + tail_len + 2;
            end else begin
                push_frame(random_sample(), random_sample(), 1'($urandom()),
                           1'($urandom()));
                added++;
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DUR_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_ATTACK:  attack_len  = data;
            CFG_DECAY:   decay_len   = data;
            CFG_SUSTAIN: sustain_cfg = LEVEL_W'(data);
            CFG_RELEASE: release_len = data;
            default: ;
        endcase
    endtask

    task automatic program_envelope(input logic [DUR_W-1:0] atk, input logic [DUR_W-1:0] dec,
                                    input logic [LEVEL_W-1:0] sus,
                                    input logic [DUR_W-1:0] rel);
        write_reg(CFG_ATTACK, atk);
        write_reg(CFG_DECAY, dec);
        write_reg(CFG_SUSTAIN, DUR_W'(sus));
        write_reg(CFG_RELEASE, rel);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_q.size() != 0 || scaled_frames_q.size() != 0 || in_ch.valid)
            @(posedge i_clk);
    endtask

    task automatic report_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $realtime, name, want, got);
            error_count++;
        end
    endtask

    // request driver: offer the next pending frame, predict on accept
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready)
                scaled_frames_q.push_back(envelope_step(offered));
            if (!in_ch.valid || in_ch.ready) begin
                if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    offered = pending_q.pop_front();
                    in_ch.valid         <= 1'b1;
                    in_ch.left_in       <= offered.left_s;
                    in_ch.right_in      <= offered.right_s;
                    in_ch.trigger_event <= offered.trig;
                    in_ch.release_event <= offered.rel;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // receiver: random back-pressure plus one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready   <= 1'b0;
            hold_left      <= 0;
            long_hold_done <= 1'b0;
        end else if (long_hold_arm && !long_hold_done) begin
            hold_left      <= LONG_HOLD;
            long_hold_done <= 1'b1;
            out_ch.ready   <= 1'b0;
        end else begin
            if (hold_left != 0)
                hold_left <= hold_left - 1;
            out_ch.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_gain_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (scaled_frames_q.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual %h %h %h %h",
                         $realtime, out_ch.left_out, out_ch.right_out, out_ch.env_level,
                         out_ch.env_stage);
                error_count++;
            end else begin
                want = scaled_frames_q.pop_front();
                report_field("left_out", 32'(want.left_s), 32'($unsigned(out_ch.left_out)));
                report_field("right_out", 32'(want.right_s),
                             32'($unsigned(out_ch.right_out)));
                report_field("env_level", 32'(want.level), 32'(out_ch.env_level));
                report_field("env_stage", 32'(want.stage), 32'(out_ch.env_stage));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** adsr_envelope_gain: FAILED **");
            $finish;
        end
    end

    initial begin
        logic [DUR_W-1:0] max_dur;
        max_dur = '1;
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_idx           = CFG_ATTACK;
        i_cfg_data          = '0;
        in_ch.valid         = 1'b0;
        in_ch.left_in       = '0;
        in_ch.right_in      = '0;
        in_ch.trigger_event = 1'b0;
        in_ch.release_event = 1'b0;
        out_ch.ready        = 1'b0;
        long_hold_arm       = 1'b0;
        error_count         = 0;
        cycle_count         = 0;
        send_idle_pct       = 17;
        recv_idle_pct       = 60;
        attack_len          = '0;
        decay_len           = '0;
        sustain_cfg         = '0;
        release_len         = '0;
        env_stage_q         = ST_IDLE;
        env_count_q         = '0;
        env_level_q         = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase < 5) begin
                send_idle_pct = 17;
                recv_idle_pct = 60;
            end else if (phase < 9) begin
                send_idle_pct = 60;
                recv_idle_pct = 17;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (phase)
                0:  program_envelope(2, 2, 17'd32768, 3);
                1:  program_envelope(0, 0, 17'h1FFFF, 0);
                2:  program_envelope(1, 1, ONE_Q16, 1);
                3:  program_envelope(5, 3, 17'd0, 7);
                4:  program_envelope(max_dur, 1, 17'd40000, max_dur);
                5:  program_envelope(3, max_dur, 17'd20000, 4);
                6:  program_envelope(13, 9, 17'd65535, 21);
                7:  program_envelope(0, 6, 17'd1, 0);
                default: program_envelope(DUR_W'($urandom_range(0, 30)),
                                          DUR_W'($urandom_range(0, 30)),
                                          LEVEL_W'($urandom_range(0, 17'h1FFFF)),
                                          DUR_W'($urandom_range(0, 30)));
            endcase
            if (phase == 0) begin
                // release while idle is dropped
                push_frame(24'sh7FFFFF, -24'sh800000, 1'b0, 1'b1);
                push_frame('0, '1, 1'b0, 1'b0);
                push_frame(24'sh7FFFFF, -24'sh800000, 1'b1, 1'b0);
                push_frame(24'sh7FFFFF, -24'sh800000, 1'b0, 1'b0);
                push_frame(24'sh7FFFFF, -24'sh800000, 1'b0, 1'b0);
                push_frame(-24'sh800000, 24'sh7FFFFF, 1'b0, 1'b0);
                push_frame(-24'sh800000, 24'sh7FFFFF, 1'b0, 1'b0);
                push_frame('1, 24'sd1, 1'b0, 1'b0);
                // both events: release wins
                push_frame(24'sh7FFFFF, -24'sh800000, 1'b1, 1'b1);
                // retrigger in the middle of release
                push_frame(random_sample(), random_sample(), 1'b1, 1'b0);
                for (int k = 0; k < 3; k++)
                    push_frame(random_sample(), random_sample(), 1'b0, 1'b0);
                push_frame(random_sample(), random_sample(), 1'b0, 1'b1);
                for (int k = 0; k < 4; k++)
                    push_frame(random_sample(), random_sample(), 1'b0, 1'b0);
                // both events from idle
                push_frame(24'sh7FFFFF, -24'sh800000, 1'b1, 1'b1);
                for (int k = 0; k < 4; k++)
                    push_frame(random_sample(), random_sample(), 1'b0, 1'b0);
            end else begin
                add_random_frames(PHASE_FRAMES);
            end
            if (phase == 10)
                long_hold_arm <= 1'b1;
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && scaled_frames_q.size() == 0)
            $display("** adsr_envelope_gain: PASSED **");
        else
            $display("** adsr_envelope_gain: FAILED **");
        $finish;
    end

endmodule
